// File: hw/rtl/itoa_pkg.sv
// Package for the radix integer-to-text converter.
// Holds the controller state type, the radix limits, the character codes and the digit glyph function.
// It has no dependencies; the top level imports it.
package itoa_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_LOAD,
    ST_HOLD
  } itoa_state_t;

  // Radix limits and the one radix that prints a sign.
  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_DEC = 5'd10;

  // ASCII codes used by the converter.
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LETTER = 8'h37;  // 'A' minus ten

  // Maps a digit from 0 to 15 onto '0'-'9' and 'A'-'F'.
  function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
    logic [7:0] wide;
    wide = {4'h0, digit};
    if (digit < 4'd10) begin
      digit_glyph = CHAR_ZERO + wide;
    end else begin
      digit_glyph = CHAR_LETTER + wide;
    end
  endfunction

endpackage

// File: hw/rtl/integer_to_ascii_radix.sv
// Top level of the radix integer-to-text converter.
// Holds the bit-serial divider, the digit memory and the output register.
// Depends on itoa_pkg for the state type, radix limits and character codes.
//
//   Channel | Handshake           | Payload               | Direction
//   --------+---------------------+-----------------------+----------
//   input   | in_valid / in_stall | value, base           | in
//   output  | out_valid/out_stall | char_code, last       | out
//
// One item at a time. The magnitude goes through a shift register one bit per
// cycle against a 4-bit remainder, so each digit takes a full division pass.
// All digits are found first; then a leading '-' passes through the sign and
// hold states, and each digit through the fetch, load and hold states.
// Reset is synchronous and clears the controller and the output valid flag.
// Output stalls hold the current character; input is stalled until the last
// character of the item has been taken.
module integer_to_ascii_radix #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [4:0]            base,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            char_code,
  output logic                  last
);
  import itoa_pkg::*;

  localparam int ADDR_W = $clog2(VALUE_BITS);
  localparam logic [ADDR_W-1:0] BIT_LAST = ADDR_W'(VALUE_BITS - 1);

  itoa_state_t state;
  itoa_state_t state_next;

  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  logic [4:0]            radix;
  logic [3:0]            rem;
  logic [ADDR_W-1:0]     bitcnt;
  logic [ADDR_W-1:0]     ndig;
  logic [ADDR_W-1:0]     ptr;
  logic                  nz;
  logic [3:0]            digit_rd;
  logic [3:0]            digit_mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] mag_in;
  logic [4:0]            radix_in;
  logic [4:0]            trial;
  logic                  qbit;
  logic [4:0]            rem_step;
  logic                  pass_end;
  logic                  quot_nz;
  logic                  sign_needed;

  // Magnitude and clamped radix of the incoming item.
  always_comb begin
    mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    if (base < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = base;
    end
  end

  // One restoring division step: bring in the next magnitude bit.
  always_comb begin
    trial       = {rem, mag[VALUE_BITS-1]};
    qbit        = (trial >= radix);
    rem_step    = qbit ? (trial - radix) : trial;
    pass_end    = (bitcnt == BIT_LAST);
    quot_nz     = nz | qbit;
    sign_needed = negative && (radix == RADIX_DEC);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (pass_end && !quot_nz) begin
          state_next = sign_needed ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN:  state_next = ST_HOLD;
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_HOLD;
      ST_HOLD: begin
        if (!out_stall) begin
          state_next = last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The output register holds a character exactly while in the hold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_next == ST_HOLD);
    end
  end

  // Datapath: divider shift register, digit counters and output payload.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mag      <= mag_in;
          negative <= value[VALUE_BITS-1];
          radix    <= radix_in;
          rem      <= 4'd0;
          bitcnt   <= '0;
          ndig     <= '0;
          nz       <= 1'b0;
        end
      end
      ST_DIV: begin
        mag <= {mag[VALUE_BITS-2:0], qbit};
        if (pass_end) begin
          rem    <= 4'd0;
          bitcnt <= '0;
          nz     <= 1'b0;
          ndig   <= ndig + 1'b1;
          ptr    <= ndig;
        end else begin
          rem    <= rem_step[3:0];
          bitcnt <= bitcnt + 1'b1;
          nz     <= quot_nz;
        end
      end
      ST_SIGN: begin
        char_code <= CHAR_MINUS;
        last      <= 1'b0;
      end
      ST_FETCH: begin
      end
      ST_LOAD: begin
        // Step down to the next digit; after the last one the pointer is unused.
        char_code <= digit_glyph(digit_rd);
        last      <= (ptr == '0);
        ptr       <= ptr - 1'b1;
      end
      ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // Digit memory: remainders are written least significant first and read
  // back from the top down.
  always_ff @(posedge clk) begin
    if (state == ST_DIV && pass_end) begin
      digit_mem[ndig] <= rem_step[3:0];
    end
    digit_rd <= digit_mem[ptr];
  end

  // The input side opens only when no character is waiting.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input accepted while a character is pending");

  // A loaded digit is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> out_valid)
    else $error("loaded digit not presented");

  // Taking the last character returns the block to idle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (state == ST_IDLE))
    else $error("item did not end after its last character");

  // The divisor stays within the clamped range while dividing.
  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (radix >= RADIX_MIN && radix <= RADIX_MAX))
    else $error("radix out of range during division");

endmodule

// File: tb/integer_to_ascii_radix_tb.sv
// Self-checking testbench for the radix integer-to-text converter.
// Predicts the character text of each accepted item and checks every output item.
// Depends on itoa_pkg and integer_to_ascii_radix.
module integer_to_ascii_radix_tb;
  import itoa_pkg::*;

  localparam int          WIDTH   = 32;
  localparam logic [7:0]  GLYPH_A = 8'h41;
  localparam int          PERIOD  = 8;

  // One expected character of a value's text.
  typedef struct packed {
    logic [7:0] code;
    logic       tail;
  } text_char_t;

  // Holds the characters still owed by the block and checks each one as it leaves.
  class text_scoreboard;
    text_char_t expected_text[$];
    int         mismatches = 0;

    // Works out the whole text of an accepted item and queues its characters.
    function void note_item(input logic [WIDTH-1:0] v, input logic [4:0] b);
      logic [4:0]       radix;
      logic [WIDTH-1:0] mag;
      logic [WIDTH-1:0] divisor;
      logic [3:0]       digit;
      logic [7:0]       rev [WIDTH+2];
      int               nd;
      radix = b;
      if (radix < RADIX_MIN) begin
        radix = RADIX_MIN;
      end
      if (radix > RADIX_MAX) begin
        radix = RADIX_MAX;
      end
      divisor = {{(WIDTH-5){1'b0}}, radix};
      // Unsigned negation keeps the most negative value as its own magnitude.
      mag = v[WIDTH-1] ? (~v + 1'b1) : v;
      nd = 0;
      if (mag == '0) begin
        rev[0] = CHAR_ZERO;
        nd = 1;
      end
      while (mag != '0) begin
        digit = 4'(mag % divisor);
        if (digit < 4'd10) begin
          rev[nd] = CHAR_ZERO + {4'h0, digit};
        end else begin
          rev[nd] = GLYPH_A + {4'h0, digit} - 8'd10;
        end
        mag = mag / divisor;
        nd++;
      end
      // Only base ten shows a sign.
      if (v[WIDTH-1] && radix == RADIX_DEC) begin
        expected_text.push_back({CHAR_MINUS, 1'b0});
      end
      for (int i = nd - 1; i >= 0; i--) begin
        expected_text.push_back({rev[i], i == 0});
      end
    endfunction

    // Compares one output item with the oldest expected character.
    function void check_char(input logic [7:0] code, input logic is_last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected item, expected none, got char_code %h last %b",
                 $time, code, is_last);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (code !== want.code) begin
        $display("%0t: char_code expected %h got %h", $time, want.code, code);
        mismatches++;
      end
      if (is_last !== want.tail) begin
        $display("%0t: last expected %b got %b", $time, want.tail, is_last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic signed [WIDTH-1:0] value     = '0;
  logic [4:0]              base      = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              char_code;
  logic                    last;

  text_scoreboard text_sb = new();
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  integer_to_ascii_radix #(.VALUE_BITS(WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .base      (base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  initial begin
    forever #(PERIOD / 2) clk = ~clk;
  end

  // Receiver: check each accepted character, then decide on the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      text_sb.check_char(char_code, last);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one item, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_item(input logic [WIDTH-1:0] v, input logic [4:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    base     <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    text_sb.note_item(v, b);
  endtask

  // Drops valid and holds off until every expected character has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (text_sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random items: full-width values, small values of either sign and edge values.
  task automatic random_items(input int count);
    logic [WIDTH-1:0] v;
    logic [4:0]       b;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom_range(0, 999);
        2: v = -$urandom_range(1, 999);
        default: begin
          case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            default: v = '0;
          endcase
        end
      endcase
      if ($urandom_range(3) == 0) begin
        b = 5'($urandom_range(0, 31));
      end else begin
        b = 5'($urandom_range(2, 16));
      end
      send_item(v, b);
    end
  endtask

  // Stimulus: directed cases, then three random phases with different idling.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 25;
    recv_stall_pct = 52;
    send_item(32'd0, 5'd10);
    send_item(32'd0, 5'd2);
    send_item(32'd0, 5'd16);
    send_item(32'h7FFF_FFFF, 5'd10);
    send_item(32'h8000_0000, 5'd10);
    send_item(32'h8000_0000, 5'd2);
    send_item(32'h8000_0000, 5'd16);
    send_item(32'h8000_0000, 5'd8);
    send_item(32'hFFFF_FFFF, 5'd10);
    send_item(32'hFFFF_FFFF, 5'd2);
    send_item(32'hFFFF_FFFF, 5'd16);
    send_item(32'd255, 5'd16);
    send_item(-32'sd255, 5'd16);
    send_item(32'd10, 5'd0);
    send_item(32'd10, 5'd1);
    send_item(32'd1000, 5'd17);
    send_item(32'd1000, 5'd31);
    send_item(32'd1, 5'd2);
    send_item(32'd100, 5'd3);
    send_item(32'd12345, 5'd7);
    send_item(-32'sd987654, 5'd12);
    send_item(32'hABCD_EF01, 5'd16);
    send_item(32'd1295, 5'd6);
    drain();

    random_items(32);
    drain();

    send_idle_pct  = 52;
    recv_stall_pct = 25;
    random_items(32);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_items(32);
    drain();

    // Give a stray extra character time to show up.
    repeat (200) @(posedge clk);
    if (text_sb.mismatches == 0 && text_sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(PERIOD * 2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/itoa_pkg.sv
hw/rtl/integer_to_ascii_radix.sv
tb/integer_to_ascii_radix_tb.sv
